// ===== src/ardl_pkg.sv =====
// Arc ray depth lookup: shared types and constants.
// Used by ardl_table, ardl_sqrt and arc_ray_depth_lookup_top; no dependencies.
package ardl_pkg;

    localparam int unsigned ROOT_W = 32;
    localparam int unsigned ARG_W  = 64;
    localparam int unsigned REM_W  = 35;

    localparam logic signed [31:0] DEPTH_SENTINEL = -32'sd255974;
    localparam logic [15:0]        LOSS_ONE       = 16'd32768;

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_QUERY = 1'b1
    } mode_t;

    typedef struct packed {
        logic               query;
        logic               beyond;
        logic signed [31:0] range;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [62:0]        radius_sq;
        logic               below;
        logic [15:0]        loss;
    } hit_t;

    typedef struct packed {
        logic               query;
        logic               beyond;
        logic               neg;
        logic               below;
        logic signed [31:0] center_y;
        logic [15:0]        loss;
    } side_t;

endpackage

// ===== src/ardl_table.sv =====
// Segment table: storage, parallel end-range compare, priority select, read.
// Depends on ardl_pkg.
module ardl_table #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               in_valid,
    input  logic               in_mode,
    input  logic [5:0]         in_index,
    input  logic signed [31:0] in_range,
    input  logic signed [31:0] in_xmax,
    input  logic signed [31:0] in_center_x,
    input  logic signed [31:0] in_center_y,
    input  logic [62:0]        in_radius_sq,
    input  logic               in_below,
    input  logic [15:0]        in_loss,
    input  logic [6:0]         segment_count,
    output logic               out_valid,
    output ardl_pkg::hit_t     out_hit
);

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    logic signed [31:0] xmax_reg [MAX_SEGMENTS];
    logic signed [31:0] cx_mem   [MAX_SEGMENTS];
    logic signed [31:0] cy_mem   [MAX_SEGMENTS];
    logic [62:0]        rsq_mem  [MAX_SEGMENTS];
    logic               blw_mem  [MAX_SEGMENTS];
    logic [15:0]        loss_mem [MAX_SEGMENTS];

    logic                    load_en;
    logic [IW-1:0]           slot;
    logic [MAX_SEGMENTS-1:0] lt;
    logic [CW-1:0]           cnt_c;

    logic                    a_valid_reg;
    logic                    a_query_reg;
    logic [MAX_SEGMENTS-1:0] a_lt_reg;
    logic [CW-1:0]           a_cnt_reg;
    logic signed [31:0]      a_range_reg;

    logic [MAX_SEGMENTS-1:0] masked;
    logic [IW-1:0]           found;
    logic [IW-1:0]           prev;
    logic [IW-1:0]           last;
    logic                    a_beyond;

    logic                    b_valid_reg;
    logic                    b_query_reg;
    logic                    b_beyond_reg;
    logic                    b_first_reg;
    logic signed [31:0]      b_range_reg;
    logic signed [31:0]      b_cx_reg;
    logic signed [31:0]      b_cy_reg;
    logic [62:0]             b_rsq_reg;
    logic                    b_below_reg;
    logic [15:0]             b_loss_reg;

    assign load_en = advance && in_valid && (in_mode == ardl_pkg::MODE_LOAD)
                     && (32'(in_index) < 32'(MAX_SEGMENTS));
    assign slot    = IW'(in_index);

    always_ff @(posedge aclk) begin
        if (load_en) begin
            xmax_reg[slot] <= in_xmax;
            cx_mem[slot]   <= in_center_x;
            cy_mem[slot]   <= in_center_y;
            rsq_mem[slot]  <= in_radius_sq;
            blw_mem[slot]  <= in_below;
            loss_mem[slot] <= in_loss;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            lt[i] = in_range < xmax_reg[i];
        end
        if (32'(segment_count) > 32'(MAX_SEGMENTS)) begin
            cnt_c = CW'(MAX_SEGMENTS);
        end else begin
            cnt_c = CW'(segment_count);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_query_reg <= in_mode == ardl_pkg::MODE_QUERY;
            a_lt_reg    <= lt;
            a_cnt_reg   <= cnt_c;
            a_range_reg <= in_range;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            masked[i] = a_lt_reg[i] && (32'(i) < 32'(a_cnt_reg));
        end
        found = '0;
        for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
            if (masked[i]) begin
                found = IW'(i);
            end
        end
        prev     = found - 1'b1;
        last     = IW'(a_cnt_reg - 1'b1);
        a_beyond = (a_cnt_reg == '0) || !a_lt_reg[last];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (advance) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            b_query_reg  <= a_query_reg;
            b_beyond_reg <= a_beyond;
            b_first_reg  <= found == '0;
            b_range_reg  <= a_range_reg;
            b_cx_reg     <= cx_mem[found];
            b_cy_reg     <= cy_mem[found];
            b_rsq_reg    <= rsq_mem[found];
            b_below_reg  <= blw_mem[found];
            b_loss_reg   <= loss_mem[prev];
        end
    end

    assign out_valid          = b_valid_reg;
    assign out_hit.query      = b_query_reg;
    assign out_hit.beyond     = b_beyond_reg;
    assign out_hit.range      = b_range_reg;
    assign out_hit.center_x   = b_cx_reg;
    assign out_hit.center_y   = b_cy_reg;
    assign out_hit.radius_sq  = b_rsq_reg;
    assign out_hit.below      = b_below_reg;
    assign out_hit.loss       = b_first_reg ? ardl_pkg::LOSS_ONE : b_loss_reg;

endmodule

// ===== src/ardl_sqrt.sv =====
// Pipelined integer square root of a 64-bit value, two result bits per stage.
// Depends on ardl_pkg; carries a side_t payload alongside each value.
module ardl_sqrt (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              advance,
    input  logic                              in_valid,
    input  logic [ardl_pkg::ARG_W-1:0]        in_arg,
    input  ardl_pkg::side_t                   in_side,
    output logic                              out_valid,
    output logic [ardl_pkg::ROOT_W-1:0]       out_root,
    output ardl_pkg::side_t                   out_side
);

    localparam int STAGES = ardl_pkg::ROOT_W / 2;

    typedef struct packed {
        logic [ardl_pkg::REM_W-1:0]  rem;
        logic [ardl_pkg::ROOT_W-1:0] root;
        logic [ardl_pkg::ARG_W-1:0]  arg;
    } sq_t;

    function automatic sq_t step(input sq_t s);
        sq_t                        r;
        logic [ardl_pkg::REM_W-1:0] rem2;
        logic [ardl_pkg::REM_W-1:0] trial;
        rem2  = {s.rem[ardl_pkg::REM_W-3:0], s.arg[ardl_pkg::ARG_W-1 -: 2]};
        trial = ardl_pkg::REM_W'({s.root, 2'b01});
        r.arg = {s.arg[ardl_pkg::ARG_W-3:0], 2'b00};
        if (rem2 >= trial) begin
            r.rem  = rem2 - trial;
            r.root = {s.root[ardl_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = rem2;
            r.root = {s.root[ardl_pkg::ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    sq_t             st_reg    [STAGES];
    sq_t             st_next   [STAGES];
    ardl_pkg::side_t side_reg  [STAGES];
    logic            valid_reg [STAGES];

    always_comb begin
        sq_t first;
        first.rem  = '0;
        first.root = '0;
        first.arg  = in_arg;
        st_next[0] = step(step(first));
        for (int k = 1; k < STAGES; k++) begin
            st_next[k] = step(step(st_reg[k-1]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < STAGES; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (advance) begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < STAGES; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            side_reg[0] <= in_side;
            for (int k = 1; k < STAGES; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 0; k < STAGES; k++) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_root  = st_reg[STAGES-1].root;
    assign out_side  = side_reg[STAGES-1];

endmodule

// ===== src/arc_ray_depth_lookup_top.sv =====
// Arc ray depth lookup top level: input register, table, arithmetic and output.
// Depends on ardl_pkg, ardl_table and ardl_sqrt.
// Query path: input register, table, d, p and r registers, root stages, output register.
// Throughput: one transaction per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous on aresetn low; clears valid bits and segment_count, table undefined.
module arc_ray_depth_lookup_top #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [6:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [5:0]         s_seg_index,
    input  logic signed [31:0] s_range,
    input  logic signed [31:0] s_seg_xmax,
    input  logic signed [31:0] s_seg_center_x,
    input  logic signed [31:0] s_seg_center_y,
    input  logic [62:0]        s_seg_radius_sq,
    input  logic               s_seg_below,
    input  logic [15:0]        s_seg_loss,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_depth,
    output logic [15:0]        m_loss_factor,
    output logic               m_beyond,
    output logic               m_sqrt_negative
);

    logic               advance;
    logic [6:0]         count_reg;

    logic               i_valid_reg;
    logic               i_mode_reg;
    logic [5:0]         i_index_reg;
    logic signed [31:0] i_range_reg;
    logic signed [31:0] i_xmax_reg;
    logic signed [31:0] i_cx_reg;
    logic signed [31:0] i_cy_reg;
    logic [62:0]        i_rsq_reg;
    logic               i_below_reg;
    logic [15:0]        i_loss_reg;

    logic               t_valid;
    ardl_pkg::hit_t     t_hit;

    logic signed [32:0] dx;
    logic [32:0]        adx;
    logic               d_valid_reg;
    ardl_pkg::hit_t     d_hit_reg;
    logic [32:0]        d_adx_reg;

    logic               p_valid_reg;
    ardl_pkg::hit_t     p_hit_reg;
    logic [65:0]        p_dx2_reg;

    logic [65:0]        rsq_x;
    logic               r_valid_reg;
    logic [63:0]        r_arg_reg;
    ardl_pkg::side_t    r_side_reg;
    ardl_pkg::side_t    r_side_next;

    logic               q_valid;
    logic [31:0]        q_root;
    ardl_pkg::side_t    q_side;
    logic signed [33:0] depth_x;
    logic signed [31:0] depth_sat;

    logic               m_valid_reg;
    logic signed [31:0] m_depth_reg;
    logic [15:0]        m_loss_reg;
    logic               m_beyond_reg;
    logic               m_neg_reg;

    assign advance   = !m_valid_reg || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_valid) begin
            count_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_valid_reg <= 1'b0;
        end else if (advance) begin
            i_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            i_mode_reg  <= s_mode;
            i_index_reg <= s_seg_index;
            i_range_reg <= s_range;
            i_xmax_reg  <= s_seg_xmax;
            i_cx_reg    <= s_seg_center_x;
            i_cy_reg    <= s_seg_center_y;
            i_rsq_reg   <= s_seg_radius_sq;
            i_below_reg <= s_seg_below;
            i_loss_reg  <= s_seg_loss;
        end
    end

    ardl_table #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_table (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .in_valid     (i_valid_reg),
        .in_mode      (i_mode_reg),
        .in_index     (i_index_reg),
        .in_range     (i_range_reg),
        .in_xmax      (i_xmax_reg),
        .in_center_x  (i_cx_reg),
        .in_center_y  (i_cy_reg),
        .in_radius_sq (i_rsq_reg),
        .in_below     (i_below_reg),
        .in_loss      (i_loss_reg),
        .segment_count(count_reg),
        .out_valid    (t_valid),
        .out_hit      (t_hit)
    );

    assign dx  = 33'(t_hit.range) - 33'(t_hit.center_x);
    assign adx = dx[32] ? 33'(-dx) : 33'(dx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end else if (advance) begin
            d_valid_reg <= t_valid && t_hit.query;
            p_valid_reg <= d_valid_reg;
            r_valid_reg <= p_valid_reg;
        end
    end

    assign rsq_x = 66'(p_hit_reg.radius_sq);

    always_comb begin
        r_side_next.query    = p_hit_reg.query;
        r_side_next.beyond   = p_hit_reg.beyond;
        r_side_next.neg      = rsq_x < p_dx2_reg;
        r_side_next.below    = p_hit_reg.below;
        r_side_next.center_y = p_hit_reg.center_y;
        r_side_next.loss     = p_hit_reg.loss;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            d_hit_reg  <= t_hit;
            d_adx_reg  <= adx;
            p_hit_reg  <= d_hit_reg;
            p_dx2_reg  <= 66'(d_adx_reg) * 66'(d_adx_reg);
            r_side_reg <= r_side_next;
            r_arg_reg  <= r_side_next.neg ? 64'd0 : 64'(rsq_x - p_dx2_reg);
        end
    end

    ardl_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_valid (r_valid_reg),
        .in_arg   (r_arg_reg),
        .in_side  (r_side_reg),
        .out_valid(q_valid),
        .out_root (q_root),
        .out_side (q_side)
    );

    always_comb begin
        if (q_side.below) begin
            depth_x = 34'(q_side.center_y) - 34'(q_root);
        end else begin
            depth_x = 34'(q_side.center_y) + 34'(q_root);
        end
        if (depth_x > 34'sd2147483647) begin
            depth_sat = 32'sh7fffffff;
        end else if (depth_x < -34'sd2147483648) begin
            depth_sat = 32'sh80000000;
        end else begin
            depth_sat = 32'(depth_x);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (q_side.beyond) begin
                m_depth_reg  <= ardl_pkg::DEPTH_SENTINEL;
                m_loss_reg   <= '0;
                m_beyond_reg <= 1'b1;
                m_neg_reg    <= 1'b0;
            end else begin
                m_depth_reg  <= depth_sat;
                m_loss_reg   <= q_side.loss;
                m_beyond_reg <= 1'b0;
                m_neg_reg    <= q_side.neg;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_depth         = m_depth_reg;
    assign m_loss_factor   = m_loss_reg;
    assign m_beyond        = m_beyond_reg;
    assign m_sqrt_negative = m_neg_reg;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for arc_ray_depth_lookup_top: segment loads, depth queries, count changes.
// Depends on ardl_pkg and the RTL top level; predicts each query result and compares in order.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic               mode;
        logic [5:0]         seg_index;
        logic signed [31:0] range;
        logic signed [31:0] xmax;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [62:0]        rsq;
        logic               below;
        logic [15:0]        loss;
    } ray_item_t;

    typedef struct {
        logic signed [31:0] depth;
        logic [15:0]        loss;
        logic               beyond;
        logic               neg;
    } depth_res_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [6:0]         cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_mode = 1'b0;
    logic [5:0]         s_seg_index = '0;
    logic signed [31:0] s_range = '0;
    logic signed [31:0] s_seg_xmax = '0;
    logic signed [31:0] s_seg_center_x = '0;
    logic signed [31:0] s_seg_center_y = '0;
    logic [62:0]        s_seg_radius_sq = '0;
    logic               s_seg_below = 1'b0;
    logic [15:0]        s_seg_loss = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_depth;
    logic [15:0]        m_loss_factor;
    logic               m_beyond;
    logic               m_sqrt_negative;

    arc_ray_depth_lookup_top DUT (.*);

    ray_item_t  pending_items[$];
    depth_res_t expected_depths[$];
    ray_item_t  cur_item;
    logic [6:0] seg_count;
    logic signed [31:0] t_xmax[64], t_cx[64], t_cy[64];
    logic [62:0] t_rsq[64];
    logic        t_below[64];
    logic [15:0] t_loss[64];
    bit          failed = 0;
    bit          idle_en = 0;
    bit          hold_off = 0;
    bit          s_acc = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r, b, rem;
        rem = x;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic predict_depth(input ray_item_t it);
        depth_res_t r;
        int cnt, hit;
        logic signed [64:0] dx, d;
        logic [63:0] adx, dx2, arg;
        if (it.mode == ardl_pkg::MODE_LOAD) begin
            t_xmax[it.seg_index] = it.xmax;
            t_cx[it.seg_index] = it.cx;
            t_cy[it.seg_index] = it.cy;
            t_rsq[it.seg_index] = it.rsq;
            t_below[it.seg_index] = it.below;
            t_loss[it.seg_index] = it.loss;
            return;
        end
        cnt = seg_count > 64 ? 64 : seg_count;
        r.neg = 0;
        if (cnt == 0 || it.range >= t_xmax[cnt-1]) begin
            r.depth = ardl_pkg::DEPTH_SENTINEL;
            r.loss = 0;
            r.beyond = 1;
        end else begin
            hit = cnt - 1;
            for (int k = cnt - 1; k >= 0; k--)
                if (it.range < t_xmax[k]) hit = k;
            r.beyond = 0;
            r.loss = hit > 0 ? t_loss[hit-1] : ardl_pkg::LOSS_ONE;
            dx = 65'(it.range) - 65'(t_cx[hit]);
            adx = dx < 0 ? 64'(-dx) : 64'(dx);
            dx2 = adx * adx;
            if ({1'b0, t_rsq[hit]} >= dx2) arg = {1'b0, t_rsq[hit]} - dx2;
            else begin
                arg = 0;
                r.neg = 1;
            end
            d = t_below[hit] ? 65'(t_cy[hit]) - 65'(int_sqrt(arg))
                             : 65'(t_cy[hit]) + 65'(int_sqrt(arg));
            if (d > 65'sd2147483647) d = 65'sd2147483647;
            if (d < -65'sd2147483648) d = -65'sd2147483648;
            r.depth = d[31:0];
        end
        expected_depths.push_back(r);
    endtask

    function automatic ray_item_t load_item(input int idx, input logic signed [31:0] xmax);
        ray_item_t it;
        it.mode = ardl_pkg::MODE_LOAD;
        it.seg_index = 6'(idx);
        it.range = $urandom;
        it.xmax = xmax;
        it.cx = $urandom;
        it.cy = $urandom;
        it.rsq = 63'({$urandom, $urandom});
        it.below = 1'($urandom);
        it.loss = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768));
        return it;
    endfunction

    function automatic ray_item_t query_item(input logic signed [31:0] rng);
        ray_item_t it;
        it = load_item($urandom, $urandom);
        it.mode = ardl_pkg::MODE_QUERY;
        it.range = rng;
        return it;
    endfunction

    // Near-miss root arguments: radius squared close to dx squared.
    function automatic ray_item_t arc_load(input int idx, input logic signed [31:0] xmax);
        ray_item_t it;
        logic [63:0] d;
        it = load_item(idx, xmax);
        if ($urandom_range(0, 1)) begin
            d = $urandom_range(0, 20000);
            it.cx = xmax - 32'(d);
            it.rsq = 63'(d * d) + 63'($urandom_range(0, 6)) - 63'd3;
        end
        return it;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_valid || expected_depths.size() != 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_count(input logic [6:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        seg_count = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_ray(input int n, input bit sorted);
        logic signed [31:0] x;
        x = -32'sd2000000 + $signed($urandom_range(0, 100000));
        for (int i = 0; i < n; i++) begin
            x = sorted ? x + $signed($urandom_range(1, 60000)) : $urandom;
            pending_items.push_back(arc_load(i, x));
        end
    endtask

    // Queries mostly near the ends of randomly chosen segments.
    task automatic random_queries(input int n, input int cnt);
        int k;
        logic signed [31:0] q;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, cnt - 1);
            case ($urandom_range(0, 5))
                0: q = $urandom;
                1: q = t_xmax[k];
                2: q = t_xmax[k] - 1;
                default: q = t_xmax[k] - $signed($urandom_range(0, 40000));
            endcase
            pending_items.push_back(query_item(q));
        end
    endtask

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_acc)) begin
            if (pending_items.size() != 0 && !(idle_en && $urandom_range(0, 99) < 25)) begin
                cur_item = pending_items.pop_front();
                s_valid <= 1'b1;
                s_mode <= cur_item.mode;
                s_seg_index <= cur_item.seg_index;
                s_range <= cur_item.range;
                s_seg_xmax <= cur_item.xmax;
                s_seg_center_x <= cur_item.cx;
                s_seg_center_y <= cur_item.cy;
                s_seg_radius_sq <= cur_item.rsq;
                s_seg_below <= cur_item.below;
                s_seg_loss <= cur_item.loss;
            end else begin
                s_valid <= 1'b0;
            end
        end
        if (aresetn)
            m_ready <= !hold_off && !(idle_en && $urandom_range(0, 99) < 25);
    end

    always @(posedge aclk) begin
        ray_item_t it;
        depth_res_t e;
        s_acc = aresetn && s_valid && s_ready;
        if (s_acc) begin
            it.mode = s_mode;
            it.seg_index = s_seg_index;
            it.range = s_range;
            it.xmax = s_seg_xmax;
            it.cx = s_seg_center_x;
            it.cy = s_seg_center_y;
            it.rsq = s_seg_radius_sq;
            it.below = s_seg_below;
            it.loss = s_seg_loss;
            predict_depth(it);
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_depths.size() == 0) begin
                $error("unexpected result transaction");
                failed = 1;
            end else begin
                e = expected_depths.pop_front();
                if (m_depth !== e.depth) begin
                    $error("depth expected %0d actual %0d", e.depth, m_depth);
                    failed = 1;
                end
                if (m_loss_factor !== e.loss) begin
                    $error("loss_factor expected %0d actual %0d", e.loss, m_loss_factor);
                    failed = 1;
                end
                if (m_beyond !== e.beyond) begin
                    $error("beyond expected %0d actual %0d", e.beyond, m_beyond);
                    failed = 1;
                end
                if (m_sqrt_negative !== e.neg) begin
                    $error("sqrt_negative expected %0d actual %0d", e.neg, m_sqrt_negative);
                    failed = 1;
                end
            end
        end
    end

    initial begin
        ray_item_t it;
        seg_count = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty table: always beyond
        pending_items.push_back(query_item(32'sh80000000));
        pending_items.push_back(query_item(32'sh7fffffff));
        pending_items.push_back(query_item(0));
        // extremes, exact root zero, overflow both ways, odd loss, ignored slot values
        it = load_item(0, 32'sh80000001);
        it.cx = 32'sh80000000; it.cy = 32'sh7fffff00; it.rsq = '1; it.below = 0;
        it.loss = 16'hffff;
        pending_items.push_back(it);
        it = load_item(1, 32'sh7fffffff);
        it.cx = 100; it.cy = 32'sh80000000; it.rsq = 63'd400; it.below = 1; it.loss = 0;
        pending_items.push_back(it);
        it = load_item(2, 32'sh7fffffff);
        it.cx = 0; it.cy = 0; it.rsq = 0; it.below = 0; it.loss = 16'd32768;
        pending_items.push_back(it);
        it = load_item(63, 32'sh7fffffff);
        it.cx = 32'sh7fffffff; it.cy = 32'sh7fffffff; it.rsq = 63'd1 << 40; it.below = 0;
        it.loss = 16'h8000;
        pending_items.push_back(it);
        for (int i = 3; i < 63; i++) pending_items.push_back(load_item(i, 32'sh7fffffff));
        wait_idle();
        write_count(7'd3);
        pending_items.push_back(query_item(32'sh80000000));
        pending_items.push_back(query_item(120));
        pending_items.push_back(query_item(80));
        pending_items.push_back(query_item(100));
        pending_items.push_back(query_item(-5000));
        pending_items.push_back(query_item(32'sh7fffffff));
        wait_idle();
        write_count(7'd127);
        pending_items.push_back(query_item(32'sh7ffffffe));
        pending_items.push_back(query_item(32'sh7fffffff));
        wait_idle();
        write_count(7'd64);
        pending_items.push_back(query_item(32'sh7ffffffe));
        wait_idle();
        write_count(7'd0);
        pending_items.push_back(query_item(5));
        wait_idle();

        // random phases, ray reloaded each time
        idle_en = 1;
        for (int ph = 0; ph < 8; ph++) begin
            int n;
            n = (ph == 0) ? 64 : (ph == 1) ? 1 : $urandom_range(1, 64);
            load_ray(n, ph != 2);
            if ($urandom_range(0, 3) == 0)
                pending_items.push_back(load_item($urandom_range(0, 63), $urandom));
            wait_idle();
            write_count(ph == 3 ? 7'd100 : 7'(n));
            if (ph == 4) idle_en = 0;
            if (ph == 5) begin
                idle_en = 1;
                hold_off = 1;
            end
            random_queries(40, n);
            if (ph == 5) begin
                repeat (200) @(posedge aclk);
                hold_off = 0;
            end
            wait_idle();
        end

        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #400us;
        $display("Test completed with failures");
        $finish;
    end
endmodule
